>>> rtl/ncns_pkg.sv
package ncns_pkg;

  localparam int HALF_SPAN   = 5;
  localparam int COUNT_WIDTH = 16;
  localparam int GRID_SIDE   = 2 * HALF_SPAN + 1;
  localparam int GRID_DEPTH  = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W      = $clog2(GRID_DEPTH);
  localparam int COORD_W     = 8;
  localparam int POS_W       = 6;
  localparam int VALUE_W     = 16;
  localparam int PERM_W      = 5;
  localparam int DIR_W       = 3;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 16;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_PLAN  = 1'b1;

  typedef logic signed [COUNT_WIDTH-1:0] count_t;
  typedef logic signed [POS_W-1:0]       pos_t;
  typedef logic        [DIR_W-1:0]       dir_t;
  typedef logic        [ADDR_W-1:0]      addr_t;
  typedef logic        [3:0][1:0]        order_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic wr_cell;
    logic issue;
    dir_t slot;
    logic load;
  } ncns_cmd_t;

  typedef struct packed {
    logic out_free;
  } ncns_status_t;

  function automatic logic signed [1:0] step_dx(input dir_t d);
    logic signed [1:0] r;
    unique case (d)
      3'd0: r = 2'sd0;
      3'd1: r = -2'sd1;
      3'd2: r = 2'sd0;
      3'd3: r = 2'sd1;
      3'd4: r = 2'sd1;
      3'd5: r = 2'sd1;
      3'd6: r = -2'sd1;
      default: r = -2'sd1;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] step_dy(input dir_t d);
    logic signed [1:0] r;
    unique case (d)
      3'd0: r = -2'sd1;
      3'd1: r = 2'sd0;
      3'd2: r = 2'sd1;
      3'd3: r = 2'sd0;
      3'd4: r = 2'sd1;
      3'd5: r = -2'sd1;
      3'd6: r = -2'sd1;
      default: r = 2'sd1;
    endcase
    return r;
  endfunction

  // lehmer code, reduced modulo 24
  function automatic order_t perm_order(input logic [PERM_W-1:0] code);
    logic [PERM_W-1:0] c;
    logic [PERM_W-1:0] r;
    logic [1:0]        p0;
    logic [1:0]        p1;
    logic [1:0]        p2;
    logic [3:0][1:0]   pool;
    order_t            ord;
    c = (code >= PERM_W'(24)) ? code - PERM_W'(24) : code;
    if (c >= PERM_W'(18)) p0 = 2'd3;
    else if (c >= PERM_W'(12)) p0 = 2'd2;
    else if (c >= PERM_W'(6)) p0 = 2'd1;
    else p0 = 2'd0;
    r = c - PERM_W'(6) * PERM_W'(p0);
    if (r >= PERM_W'(4)) p1 = 2'd2;
    else if (r >= PERM_W'(2)) p1 = 2'd1;
    else p1 = 2'd0;
    p2 = {1'b0, r[0]};
    pool = {2'd3, 2'd2, 2'd1, 2'd0};
    ord[0] = pool[p0];
    for (int j = 0; j < 3; j++) begin
      if (j >= int'(p0)) pool[j] = pool[j+1];
    end
    ord[1] = pool[p1];
    for (int j = 0; j < 2; j++) begin
      if (j >= int'(p1)) pool[j] = pool[j+1];
    end
    ord[2] = pool[p2];
    if (p2 == 2'd0) pool[0] = pool[1];
    ord[3] = pool[0];
    return ord;
  endfunction

  function automatic count_t sat_count(input logic signed [VALUE_W-1:0] v);
    logic signed [31:0] x;
    logic signed [31:0] hi;
    logic signed [31:0] lo;
    hi = 32'sd2 ** (COUNT_WIDTH - 1) - 32'sd1;
    lo = -(32'sd2 ** (COUNT_WIDTH - 1));
    x = 32'(v);
    if (x > hi) x = hi;
    if (x < lo) x = lo;
    return COUNT_WIDTH'(x);
  endfunction

endpackage

>>> rtl/node_count_neighbor_select.sv
// node_count_neighbor_select
// Keeps an 11 by 11 grid of signed visit counts and picks the next move of a
// node-counting explorer among the 8 neighbors of a cell.
// Input stream: in_tuser = 0 stores cell_value at (cell_x, cell_y); in_tuser = 1
// plans a move from (cell_x, cell_y). A write request gives no result; a plan
// request gives exactly one result on the output stream.
// cfg_wr_en/cfg_wr_data set random_mode, which makes the scan order of the
// orthogonal and diagonal groups follow ortho_perm and diag_perm.
// Timing: a write is taken and the next request may follow at once.
// A plan reads the 8 neighbors one per cycle from the grid store, which has one
// read port; the result then passes the drain and finish states and is registered
// in the output register. No new request is taken until the plan is done.
// Reset clears every grid cell to zero (per-cell valid flags) and random_mode;
// the block is ready as soon as reset is released.
// When the receiver stalls the result stays in the output register; writes are
// still taken, and a further plan finishes its scan and then waits for it.
module node_count_neighbor_select (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // cell_x, cell_y, cell_value, ortho_perm, diag_perm, zero fill
  input  logic [ncns_pkg::IN_DATA_W-1:0]      in_tdata,
  // action
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // dest_x, dest_y, direction, zero fill
  output logic [ncns_pkg::OUT_DATA_W-1:0]     out_tdata,
  // move_found
  output logic                                out_tuser
);
  import ncns_pkg::*;

  ncns_cmd_t    cmd;
  ncns_status_t status;

  ncns_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  ncns_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule

>>> rtl/ncns_ctrl.sv
module ncns_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tuser,
  output logic                  in_tready,
  input  ncns_pkg::ncns_status_t status,
  output ncns_pkg::ncns_cmd_t    cmd
);
  import ncns_pkg::*;

  state_t state_r;
  state_t state_nxt;
  dir_t   cnt_r;
  dir_t   cnt_nxt;
  logic   accept;

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_tuser == ACT_PLAN) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (cnt_r == dir_t'(7)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (status.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt = (state_r == ST_SCAN) ? cnt_r + dir_t'(1) : '0;
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd         = '0;
    cmd.slot    = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.start   = accept && in_tuser == ACT_PLAN;
        cmd.wr_cell = accept && in_tuser == ACT_WRITE;
      end
      ST_SCAN:   cmd.issue = 1'b1;
      ST_DRAIN:  cmd.issue = 1'b0;
      ST_FINISH: cmd.load  = status.out_free;
      default:   cmd.issue = 1'b0;
    endcase
  end

endmodule

>>> rtl/ncns_datapath.sv
module ncns_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ncns_pkg::ncns_cmd_t                   cmd,
  output ncns_pkg::ncns_status_t                status,
  input  logic                                  cfg_wr_en,
  input  logic                                  cfg_wr_data,
  input  logic [ncns_pkg::IN_DATA_W-1:0]        in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [ncns_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                  out_tuser
);
  import ncns_pkg::*;

  typedef logic signed [COORD_W-1:0] coord_t;

  logic   random_mode_r;
  count_t grid_mem [GRID_DEPTH];
  logic   [GRID_DEPTH-1:0] cell_vld_r;

  pos_t              x_r;
  pos_t              y_r;
  logic [PERM_W-1:0] ortho_r;
  logic [PERM_W-1:0] diag_r;

  pos_t                     in_x;
  pos_t                     in_y;
  logic signed [VALUE_W-1:0] in_value;
  coord_t                   wr_gx;
  coord_t                   wr_gy;
  addr_t                    wr_addr;
  logic                     wr_hit;

  order_t ortho_ord;
  order_t diag_ord;
  dir_t   nb_dir;
  coord_t nb_gx;
  coord_t nb_gy;
  addr_t  rd_addr;
  logic   nb_in;

  count_t rd_data_r;
  logic   rd_vld_r;
  logic   s1_en_r;
  dir_t   s1_dir_r;
  count_t cnt_val;

  logic   found_r;
  logic   found_nxt;
  logic   stop_r;
  logic   stop_nxt;
  count_t min_r;
  count_t min_nxt;
  dir_t   best_r;
  dir_t   best_nxt;

  logic   out_valid_r;
  logic   out_valid_nxt;
  pos_t   out_x_r;
  pos_t   out_y_r;
  dir_t   out_dir_r;
  logic   out_found_r;

  function automatic logic on_grid(input coord_t gx, input coord_t gy);
    return gx >= 0 && gx < COORD_W'(GRID_SIDE) && gy >= 0 && gy < COORD_W'(GRID_SIDE);
  endfunction

  function automatic addr_t cell_addr(input coord_t gx, input coord_t gy);
    return ADDR_W'(unsigned'(gx)) * ADDR_W'(GRID_SIDE) + ADDR_W'(unsigned'(gy));
  endfunction

  // request fields
  assign in_x     = in_tdata[5:0];
  assign in_y     = in_tdata[11:6];
  assign in_value = in_tdata[27:12];

  assign wr_gx   = COORD_W'(in_x) + COORD_W'(HALF_SPAN);
  assign wr_gy   = COORD_W'(in_y) + COORD_W'(HALF_SPAN);
  assign wr_hit  = cmd.wr_cell && on_grid(wr_gx, wr_gy);
  assign wr_addr = cell_addr(wr_gx, wr_gy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      random_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      random_mode_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      grid_mem[wr_addr] <= sat_count(in_value);
    end
    rd_data_r <= grid_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_vld_r <= '0;
    end else if (wr_hit) begin
      cell_vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_r     <= in_x;
      y_r     <= in_y;
      ortho_r <= in_tdata[32:28];
      diag_r  <= in_tdata[37:33];
    end
  end

  // scan order and neighbor address
  assign ortho_ord = random_mode_r ? perm_order(ortho_r) : {2'd3, 2'd2, 2'd1, 2'd0};
  assign diag_ord  = random_mode_r ? perm_order(diag_r)  : {2'd3, 2'd2, 2'd1, 2'd0};
  assign nb_dir    = cmd.slot[2] ? {1'b1, diag_ord[cmd.slot[1:0]]}
                                 : {1'b0, ortho_ord[cmd.slot[1:0]]};
  assign nb_gx     = COORD_W'(x_r) + COORD_W'(HALF_SPAN) + COORD_W'(step_dx(nb_dir));
  assign nb_gy     = COORD_W'(y_r) + COORD_W'(HALF_SPAN) + COORD_W'(step_dy(nb_dir));
  assign nb_in     = on_grid(nb_gx, nb_gy);
  assign rd_addr   = nb_in ? cell_addr(nb_gx, nb_gy) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_en_r <= 1'b0;
    end else begin
      s1_en_r <= cmd.issue && nb_in;
    end
  end

  always_ff @(posedge clk) begin
    s1_dir_r <= nb_dir;
    rd_vld_r <= cell_vld_r[rd_addr];
  end

  assign cnt_val = rd_vld_r ? rd_data_r : '0;

  always_comb begin
    found_nxt = found_r;
    stop_nxt  = stop_r;
    min_nxt   = min_r;
    best_nxt  = best_r;
    if (cmd.start) begin
      found_nxt = 1'b0;
      stop_nxt  = 1'b0;
      best_nxt  = '0;
    end else if (s1_en_r && !stop_r && cnt_val >= 0) begin
      if (cnt_val == 0) begin
        best_nxt  = s1_dir_r;
        found_nxt = 1'b1;
        stop_nxt  = 1'b1;
      end else if (!found_r || cnt_val <= min_r) begin
        min_nxt   = cnt_val;
        best_nxt  = s1_dir_r;
        found_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      stop_r  <= 1'b0;
    end else begin
      found_r <= found_nxt;
      stop_r  <= stop_nxt;
    end
    min_r  <= min_nxt;
    best_r <= best_nxt;
  end

  // output register
  assign status.out_free = !out_valid_r || out_tready;
  assign out_valid_nxt   = cmd.load || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_found_r <= found_r;
      out_dir_r   <= found_r ? best_r : '0;
      out_x_r     <= found_r ? x_r + POS_W'(step_dx(best_r)) : x_r;
      out_y_r     <= found_r ? y_r + POS_W'(step_dy(best_r)) : y_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - 2 * POS_W - DIR_W){1'b0}}, out_dir_r, out_y_r, out_x_r};
  assign out_tuser  = out_found_r;

endmodule

>>> rtl/ncns_checker.sv
module ncns_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ncns_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                             out_tuser
);
  import ncns_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == ACT_WRITE && !out_tvalid |=> !out_tvalid)
    else $error("write request produced a result");

  a_plan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == ACT_PLAN |=> !in_tready)
    else $error("request taken during a scan");

  a_no_move_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[14:12] == 3'd0)
    else $error("direction set without a move");

endmodule

bind node_count_neighbor_select ncns_checker u_ncns_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

>>> test/node_count_neighbor_select_tb.sv
module node_count_neighbor_select_tb;
  import ncns_pkg::*;

  localparam int COUNT_CAP  = 99999;
  localparam int QUIET_CYC  = 16;
  localparam int DRAIN_CYC  = 40;
  localparam int CYCLE_CAP  = 400000;
  localparam int PHASE_REQS = 205;

  typedef struct {
    bit                        is_cfg;
    bit                        cfg_val;
    logic                      action;
    pos_t                      x;
    pos_t                      y;
    logic signed [VALUE_W-1:0] val;
    logic [PERM_W-1:0]         op;
    logic [PERM_W-1:0]         dp;
  } req_t;

  typedef struct {
    pos_t dest_x;
    pos_t dest_y;
    dir_t dir;
    logic found;
  } move_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic                  cfg_wr_data = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  int move_dx [8] = '{0, -1, 0, 1, 1, 1, -1, -1};
  int move_dy [8] = '{-1, 0, 1, 0, 1, -1, -1, 1};

  count_t visit_cnt [GRID_SIDE][GRID_SIDE];
  bit     scan_random;
  req_t   pend_q [$];
  move_t  move_q [$];
  req_t   cur_req;
  int     gap_left;
  int     quiet;
  int     stall_left;
  bit     calm;
  int     bad_moves;
  int     n_writes;
  int     n_plans;
  int     n_moves;
  int     n_found;
  int     n_cfg;
  int     cycles;

  node_count_neighbor_select uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic order_t lehmer_order(input logic [PERM_W-1:0] code);
    int     c;
    int     n;
    int     p;
    int     pool [4];
    order_t o;
    c = int'(code) % 24;
    pool = '{0, 1, 2, 3};
    n = 4;
    for (int k = 0; k < 3; k++) begin
      p = (k == 0) ? c / 6 : (k == 1) ? (c % 6) / 2 : c % 2;
      o[k] = 2'(pool[p]);
      for (int j = p; j < n - 1; j++) pool[j] = pool[j + 1];
      n--;
    end
    o[3] = 2'(pool[0]);
    return o;
  endfunction

  function automatic void store_cell(input req_t r);
    int gx;
    int gy;
    gx = int'(r.x) + HALF_SPAN;
    gy = int'(r.y) + HALF_SPAN;
    if (gx >= 0 && gx < GRID_SIDE && gy >= 0 && gy < GRID_SIDE) begin
      visit_cnt[gx][gy] = count_t'(r.val);
    end
  endfunction

  function automatic move_t select_move(input req_t r);
    order_t ord_o;
    order_t ord_d;
    int     x;
    int     y;
    int     d;
    int     gx;
    int     gy;
    int     c;
    int     minc;
    bit     done;
    move_t  m;
    x = int'(r.x);
    y = int'(r.y);
    ord_o = lehmer_order(r.op);
    ord_d = lehmer_order(r.dp);
    m.dest_x = r.x;
    m.dest_y = r.y;
    m.dir = '0;
    m.found = 1'b0;
    minc = COUNT_CAP;
    done = 1'b0;
    for (int i = 0; i < 8 && !done; i++) begin
      if (!scan_random) d = i;
      else if (i < 4) d = int'(ord_o[i]);
      else d = 4 + int'(ord_d[i - 4]);
      gx = x + HALF_SPAN + move_dx[d];
      gy = y + HALF_SPAN + move_dy[d];
      if (gx >= 0 && gx < GRID_SIDE && gy >= 0 && gy < GRID_SIDE) begin
        c = int'(visit_cnt[gx][gy]);
        if (c >= 0 && c <= minc) begin
          minc = c;
          m.dest_x = pos_t'(x + move_dx[d]);
          m.dest_y = pos_t'(y + move_dy[d]);
          m.dir = dir_t'(d);
          m.found = 1'b1;
          if (c == 0) done = 1'b1;
        end
      end
    end
    return m;
  endfunction

  // request driver
  always @(posedge clk) begin
    bit nxt_valid;
    bit fire;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_wr_en <= 1'b0;
      gap_left = 0;
      quiet = 0;
      scan_random = 1'b0;
      for (int i = 0; i < GRID_SIDE; i++)
        for (int j = 0; j < GRID_SIDE; j++) visit_cnt[i][j] = '0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (cur_req.action == ACT_WRITE) begin
          store_cell(cur_req);
          n_writes++;
        end else begin
          move_q.push_back(select_move(cur_req));
          n_plans++;
        end
      end
      if (move_q.size() == 0 && !in_tvalid) quiet++;
      else quiet = 0;
      calm = (pend_q.size() < 120);
      fire = 1'b0;
      nxt_valid = in_tvalid && !in_tready;
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pend_q.size() > 0) begin
          if (pend_q[0].is_cfg) begin
            if (quiet >= QUIET_CYC) begin
              fire = 1'b1;
              cfg_wr_data <= pend_q[0].cfg_val;
              scan_random = pend_q[0].cfg_val;
              n_cfg++;
              void'(pend_q.pop_front());
              quiet = 0;
            end
          end else begin
            cur_req = pend_q.pop_front();
            nxt_valid = 1'b1;
            in_tdata <= {2'b00, cur_req.dp, cur_req.op, cur_req.val, cur_req.y, cur_req.x};
            in_tuser <= cur_req.action;
            if (!calm && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 15);
          end
        end
      end
      in_tvalid <= nxt_valid;
      cfg_wr_en <= fire;
    end
  end

  // result monitor
  always @(posedge clk) begin
    move_t m;
    pos_t  got_x;
    pos_t  got_y;
    dir_t  got_dir;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_x = out_tdata[POS_W-1:0];
        got_y = out_tdata[2*POS_W-1:POS_W];
        got_dir = out_tdata[2*POS_W+DIR_W-1:2*POS_W];
        n_moves++;
        if (move_q.size() == 0) begin
          bad_moves++;
          if (bad_moves <= 10)
            $display("unexpected move: x=%0d y=%0d dir=%0d found=%0b",
                     got_x, got_y, got_dir, out_tuser);
        end else begin
          m = move_q.pop_front();
          if (m.found) n_found++;
          if (got_x !== m.dest_x || got_y !== m.dest_y || got_dir !== m.dir ||
              out_tuser !== m.found) begin
            bad_moves++;
            if (bad_moves <= 10)
              $display("move mismatch: exp x=%0d y=%0d dir=%0d found=%0b, got x=%0d y=%0d dir=%0d found=%0b",
                       m.dest_x, m.dest_y, m.dir, m.found,
                       got_x, got_y, got_dir, out_tuser);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void push_cfg(input bit v);
    req_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.cfg_val = v;
    pend_q.push_back(r);
  endfunction

  function automatic void push_write(input int x, input int y, input int v);
    req_t r;
    r = '{default: '0};
    r.action = ACT_WRITE;
    r.x = pos_t'(x);
    r.y = pos_t'(y);
    r.val = VALUE_W'(v);
    r.op = PERM_W'($urandom_range(0, 31));
    r.dp = PERM_W'($urandom_range(0, 31));
    pend_q.push_back(r);
  endfunction

  function automatic void push_plan(input int x, input int y, input int op, input int dp);
    req_t r;
    r = '{default: '0};
    r.action = ACT_PLAN;
    r.x = pos_t'(x);
    r.y = pos_t'(y);
    r.val = VALUE_W'($urandom_range(0, 65535));
    r.op = PERM_W'(op);
    r.dp = PERM_W'(dp);
    pend_q.push_back(r);
  endfunction

  function automatic int pick_coord();
    case ($urandom_range(0, 9))
      0: return int'($urandom_range(0, 63)) - 32;
      1: return $urandom_range(0, 1) ? 6 : -6;
      default: return int'($urandom_range(0, 10)) - 5;
    endcase
  endfunction

  function automatic int pick_count();
    case ($urandom_range(0, 9))
      0: return int'($urandom_range(0, 65535)) - 32768;
      1: return 0;
      2: return -int'($urandom_range(1, 3));
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  initial begin
    push_cfg(1'b0);
    push_plan(0, 0, 0, 0);
    push_write(-32, 31, -32768);
    // fence the center with obstacles on the orthogonals
    push_write(0, -1, -1);
    push_write(-1, 0, -1);
    push_write(0, 1, -1);
    push_write(1, 0, -1);
    push_write(1, 1, 3);
    push_write(1, -1, 2);
    push_write(-1, -1, 2);
    push_write(-1, 1, 5);
    push_plan(0, 0, 31, 31);
    push_write(1, -1, -32768);
    push_write(-1, -1, 32767);
    push_write(1, 1, -5);
    push_write(-1, 1, -1);
    push_plan(0, 0, 7, 9);
    push_write(-1, -1, -2);
    push_plan(0, 0, 0, 0);
    push_plan(-5, -5, 0, 0);
    push_plan(31, 31, 0, 0);
    push_plan(-32, -32, 0, 0);
    push_plan(6, 5, 0, 0);
    push_write(5, 5, 32767);
    push_plan(6, 5, 0, 0);
    push_cfg(1'b1);
    push_plan(0, 0, 5, 17);
    push_plan(3, 3, 0, 31);
    push_plan(3, 3, 23, 24);
    push_plan(3, 3, 24, 0);
    push_plan(3, 3, 31, 23);
    for (int ph = 0; ph < 4; ph++) begin
      push_cfg(ph % 2);
      for (int k = 0; k < PHASE_REQS; k++) begin
        if ($urandom_range(0, 9) < 3)
          push_plan(pick_coord(), pick_coord(), $urandom_range(0, 31), $urandom_range(0, 31));
        else
          push_write(pick_coord(), pick_coord(), pick_count());
      end
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pend_q.size() > 0 || in_tvalid || move_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (move_q.size() != 0) begin
      $display("%0d moves never arrived", move_q.size());
      bad_moves += move_q.size();
    end
    $display("grid writes %0d, plans %0d, moves %0d (%0d with a neighbor)",
             n_writes, n_plans, n_moves, n_found);
    $display("scan order switched %0d times between fixed and permuted", n_cfg);
    if (bad_moves == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
